// ===== rtl/mpssd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpssd_pkg
// Shared types and constants of the masked patch SSD k-best search unit.
// ----------------------------------------------------------------------------
package mpssd_pkg;

   localparam int MAX_IMAGE_SIDE = 256;
   localparam int MAX_PATCH_SIDE = 16;
   localparam int MAX_KEEP       = 8;

   localparam int IMG_DEPTH   = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
   localparam int PATCH_DEPTH = MAX_PATCH_SIDE * MAX_PATCH_SIDE;
   localparam int IMG_AW      = $clog2(IMG_DEPTH);
   localparam int PATCH_AW    = $clog2(PATCH_DEPTH);
   localparam int SIDE_W      = $clog2(MAX_IMAGE_SIDE) + 1;
   localparam int PSIDE_W     = $clog2(MAX_PATCH_SIDE) + 1;
   localparam int KEEP_W      = $clog2(MAX_KEEP) + 1;
   localparam int SLOT_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int ERR_W       = 30;
   localparam int PIX_W       = 25;

   localparam logic [ERR_W-1:0] ERR_SENTINEL = ERR_W'(1000000000);

   localparam logic [1:0] MODE_IMAGE = 2'd0;
   localparam logic [1:0] MODE_PATCH = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   localparam logic [2:0] REG_IMAGE_ROWS = 3'd0;
   localparam logic [2:0] REG_IMAGE_COLS = 3'd1;
   localparam logic [2:0] REG_PATCH_ROWS = 3'd2;
   localparam logic [2:0] REG_PATCH_COLS = 3'd3;
   localparam logic [2:0] REG_KEEP_COUNT = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] pixel_index;
      logic [7:0]  chan_a;
      logic [7:0]  chan_b;
      logic [7:0]  chan_c;
      logic        mask_bit;
   } req_type;

   typedef struct packed {
      logic [2:0]       rank;
      logic [8:0]       row_first;
      logic [8:0]       row_final;
      logic [8:0]       col_first;
      logic [8:0]       col_final;
      logic [ERR_W-1:0] error_sum;
      logic             last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_DRAIN,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;     // reset best list, window, pixel counters
      logic step;      // issue next pixel read
      logic finish;    // close current window after drain
      logic insert;    // one insertion step
      logic emit_load; // load output register
   } cmd_type;

   typedef struct packed {
      logic no_window;   // patch larger than image
      logic win_issued;  // last pixel of window issued
      logic pipe_empty;  // no reads in flight
      logic walk_done;   // last window closed
      logic ins_done;    // insertion finished
      logic emit_done;   // last slot loaded
      logic out_free;    // output register can take a new item
   } sts_type;

   function automatic logic [8:0] clamp9(input logic [8:0] v);
      if (v == 9'd0) return 9'd1;
      if (v > 9'(MAX_IMAGE_SIDE)) return 9'(MAX_IMAGE_SIDE);
      return v;
   endfunction

   function automatic logic [4:0] clamp5(input logic [4:0] v);
      if (v == 5'd0) return 5'd1;
      if (v > 5'(MAX_PATCH_SIDE)) return 5'(MAX_PATCH_SIDE);
      return v;
   endfunction

   function automatic logic [3:0] clamp4(input logic [3:0] v);
      if (v == 4'd0) return 4'd1;
      if (v > 4'(MAX_KEEP)) return 4'(MAX_KEEP);
      return v;
   endfunction

endpackage

// ===== rtl/masked_patch_ssd_k_best_search_unit.sv =====
// ----------------------------------------------------------------------------
// masked_patch_ssd_k_best_search_unit
// Masked patch SSD search keeping the best candidates, with register port.
// ----------------------------------------------------------------------------
// Load items: one per cycle while idle, no result.
// Search item: per window one store read per patch pixel, a read pipeline drain
// and an insertion into the best list, then keep_count results.
// Synchronous reset restores register defaults; pixel stores are not cleared.
module masked_patch_ssd_k_best_search_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mpssd_pkg::req_type   req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mpssd_pkg::rsp_type   rsp_item,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [8:0] image_rows_ff, image_cols_ff;
   logic [4:0] patch_rows_ff, patch_cols_ff;
   logic [3:0] keep_count_ff;
   logic       wr;
   logic [2:0] ridx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign ridx   = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff <= 9'd256;
         image_cols_ff <= 9'd256;
         patch_rows_ff <= 5'd9;
         patch_cols_ff <= 5'd9;
         keep_count_ff <= 4'd3;
      end else if (wr && paddr[1:0] == 2'd0) begin
         case (ridx)
            mpssd_pkg::REG_IMAGE_ROWS: image_rows_ff <= mpssd_pkg::clamp9(pwdata[8:0]);
            mpssd_pkg::REG_IMAGE_COLS: image_cols_ff <= mpssd_pkg::clamp9(pwdata[8:0]);
            mpssd_pkg::REG_PATCH_ROWS: patch_rows_ff <= mpssd_pkg::clamp5(pwdata[4:0]);
            mpssd_pkg::REG_PATCH_COLS: patch_cols_ff <= mpssd_pkg::clamp5(pwdata[4:0]);
            mpssd_pkg::REG_KEEP_COUNT: keep_count_ff <= mpssd_pkg::clamp4(pwdata[3:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         mpssd_pkg::REG_IMAGE_ROWS: prdata = 32'(image_rows_ff);
         mpssd_pkg::REG_IMAGE_COLS: prdata = 32'(image_cols_ff);
         mpssd_pkg::REG_PATCH_ROWS: prdata = 32'(patch_rows_ff);
         mpssd_pkg::REG_PATCH_COLS: prdata = 32'(patch_cols_ff);
         mpssd_pkg::REG_KEEP_COUNT: prdata = 32'(keep_count_ff);
         default:                   prdata = '0;
      endcase
   end

   logic busy, acc, start;
   mpssd_pkg::cmd_type cmd;
   mpssd_pkg::sts_type sts;

   assign req_ready = !busy;
   assign acc       = req_valid && req_ready;
   assign start     = acc && req_item.mode == mpssd_pkg::MODE_START;

   mpssd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   mpssd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .load_valid (acc),
      .load_item  (req_item),
      .image_rows (image_rows_ff),
      .image_cols (image_cols_ff),
      .patch_rows (patch_rows_ff),
      .patch_cols (patch_cols_ff),
      .keep_count (keep_count_ff),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== rtl/mpssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpssd_ctrl
// Search sequencer: clear, window walk, per-window insertion, result emit.
// ----------------------------------------------------------------------------
module mpssd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mpssd_pkg::sts_type  sts,
   output mpssd_pkg::cmd_type  cmd,
   output logic                busy
);

   mpssd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpssd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpssd_pkg::ST_IDLE: begin
            if (start) state_in = mpssd_pkg::ST_CLEAR;
         end
         mpssd_pkg::ST_CLEAR: begin
            state_in = sts.no_window ? mpssd_pkg::ST_EMIT : mpssd_pkg::ST_WALK;
         end
         mpssd_pkg::ST_WALK: begin
            if (sts.win_issued) state_in = mpssd_pkg::ST_DRAIN;
         end
         mpssd_pkg::ST_DRAIN: begin
            if (sts.pipe_empty) state_in = mpssd_pkg::ST_INSERT;
         end
         mpssd_pkg::ST_INSERT: begin
            if (sts.ins_done)
               state_in = sts.walk_done ? mpssd_pkg::ST_EMIT : mpssd_pkg::ST_WALK;
         end
         mpssd_pkg::ST_EMIT: begin
            if (sts.out_free && sts.emit_done) state_in = mpssd_pkg::ST_IDLE;
         end
         default: state_in = mpssd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         mpssd_pkg::ST_IDLE:   busy = 1'b0;
         mpssd_pkg::ST_CLEAR:  cmd.clear = 1'b1;
         mpssd_pkg::ST_WALK:   cmd.step = 1'b1;
         mpssd_pkg::ST_DRAIN:  cmd.finish = sts.pipe_empty;
         mpssd_pkg::ST_INSERT: cmd.insert = 1'b1;
         mpssd_pkg::ST_EMIT:   cmd.emit_load = sts.out_free;
         default:              busy = 1'b0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpssd_pkg::ST_IDLE) |-> !(cmd.step || cmd.insert || cmd.emit_load))
      else $error("datapath command while idle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpssd_pkg::ST_WALK && sts.win_issued) |=>
         (state_ff == mpssd_pkg::ST_DRAIN))
      else $error("window walk did not drain");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == mpssd_pkg::ST_INSERT))
      else $error("window close without insertion");

endmodule

// ===== rtl/mpssd_datapath.sv =====
// ----------------------------------------------------------------------------
// mpssd_datapath
// Pixel stores, window address walk, SSD accumulator, sorted best list and
// output register.
// ----------------------------------------------------------------------------
module mpssd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  mpssd_pkg::req_type   load_item,
   input  logic [8:0]           image_rows,
   input  logic [8:0]           image_cols,
   input  logic [4:0]           patch_rows,
   input  logic [4:0]           patch_cols,
   input  logic [3:0]           keep_count,
   input  mpssd_pkg::cmd_type   cmd,
   output mpssd_pkg::sts_type   sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mpssd_pkg::rsp_type   rsp_item
);

   localparam int IAW = mpssd_pkg::IMG_AW;
   localparam int PAW = mpssd_pkg::PATCH_AW;
   localparam int EW  = mpssd_pkg::ERR_W;
   localparam int SW  = mpssd_pkg::SLOT_W;
   localparam int KW  = mpssd_pkg::KEEP_W;

   logic [mpssd_pkg::PIX_W-1:0] image_mem [mpssd_pkg::IMG_DEPTH];
   logic [mpssd_pkg::PIX_W-1:0] patch_mem [mpssd_pkg::PATCH_DEPTH];

   // load path
   logic [17:0] img_lim, pat_lim;
   assign img_lim = 18'(image_rows) * 18'(image_cols);
   assign pat_lim = 18'(patch_rows) * 18'(patch_cols);

   logic [mpssd_pkg::PIX_W-1:0] load_pix;
   assign load_pix = {load_item.mask_bit, load_item.chan_c, load_item.chan_b,
                      load_item.chan_a};

   always_ff @(posedge clock) begin
      if (load_valid && load_item.mode == mpssd_pkg::MODE_IMAGE &&
          18'(load_item.pixel_index) < img_lim)
         image_mem[load_item.pixel_index[IAW-1:0]] <= load_pix;
      if (load_valid && load_item.mode == mpssd_pkg::MODE_PATCH &&
          18'(load_item.pixel_index) < pat_lim)
         patch_mem[load_item.pixel_index[PAW-1:0]] <= load_pix;
   end

   // window walk: window corner (r,c), patch offset (pr,pc)
   logic [8:0] r_ff, r_in, c_ff, c_in;
   logic [4:0] pr_ff, pr_in, pc_ff, pc_in;
   logic [17:0] iaddr_ff, iaddr_in;   // address of image pixel
   logic [17:0] col_base_ff, col_base_in;
   logic [PAW:0] paddr_ff, paddr_in;
   logic bad_ff, bad_in;              // window hit a non-source pixel
   logic wdone_ff, wdone_in;

   logic [8:0] r_max, c_max;
   assign r_max = image_rows - 9'(patch_rows);
   assign c_max = image_cols - 9'(patch_cols);

   logic last_pr, last_pc, last_r, last_c;
   assign last_pr = (pr_ff == patch_rows - 5'd1);
   assign last_pc = (pc_ff == patch_cols - 5'd1);
   assign last_r  = (r_ff == r_max);
   assign last_c  = (c_ff == c_max);

   // read pipeline: issue -> mem read -> square -> accumulate
   logic v1_ff, v2_ff;
   logic [mpssd_pkg::PIX_W-1:0] ipx_ff, ppx_ff;
   logic [17:0] sq_ff;
   logic v3_mask_ff, v3_keep_ff;
   logic [EW+1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         ipx_ff <= image_mem[iaddr_ff[IAW-1:0]];
         ppx_ff <= patch_mem[paddr_ff[PAW-1:0]];
      end
   end

   logic signed [8:0] da, db, dc;
   assign da = 9'(ipx_ff[7:0])   - 9'(ppx_ff[7:0]);
   assign db = 9'(ipx_ff[15:8])  - 9'(ppx_ff[15:8]);
   assign dc = 9'(ipx_ff[23:16]) - 9'(ppx_ff[23:16]);

   always_ff @(posedge clock) begin
      sq_ff      <= 18'(da) * 18'(da) + 18'(db) * 18'(db) + 18'(dc) * 18'(dc);
      v3_mask_ff <= ipx_ff[24];
      v3_keep_ff <= !ppx_ff[24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.step;
         v2_ff <= v1_ff;
      end
   end

   always_comb begin
      r_in = r_ff; c_in = c_ff; pr_in = pr_ff; pc_in = pc_ff;
      iaddr_in = iaddr_ff; col_base_in = col_base_ff; paddr_in = paddr_ff;
      wdone_in = wdone_ff;
      if (cmd.clear) begin
         r_in = '0; c_in = '0; pr_in = '0; pc_in = '0;
         iaddr_in = '0; col_base_in = '0; paddr_in = '0; wdone_in = 1'b0;
      end else if (cmd.step) begin
         paddr_in = paddr_ff + 1'b1;
         if (!last_pr) begin
            pr_in = pr_ff + 5'd1;
            iaddr_in = iaddr_ff + 18'd1;
         end else begin
            pr_in = '0;
            iaddr_in = iaddr_ff + 18'(image_rows) - 18'(patch_rows) + 18'd1;
            if (!last_pc) pc_in = pc_ff + 5'd1;
            else pc_in = '0;
         end
      end else if (cmd.finish) begin
         paddr_in = '0;
         if (!last_r) begin
            r_in = r_ff + 9'd1;
            iaddr_in = col_base_ff + 18'(r_ff) + 18'd1;
         end else begin
            r_in = '0;
            c_in = c_ff + 9'd1;
            col_base_in = col_base_ff + 18'(image_rows);
            iaddr_in = col_base_ff + 18'(image_rows);
            wdone_in = last_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0; c_ff <= '0; pr_ff <= '0; pc_ff <= '0;
         iaddr_ff <= '0; col_base_ff <= '0; paddr_ff <= '0; wdone_ff <= 1'b0;
      end else begin
         r_ff <= r_in; c_ff <= c_in; pr_ff <= pr_in; pc_ff <= pc_in;
         iaddr_ff <= iaddr_in; col_base_ff <= col_base_in; paddr_ff <= paddr_in;
         wdone_ff <= wdone_in;
      end
   end

   // accumulator; cleared when window closes
   always_ff @(posedge clock) begin
      if (reset || cmd.clear || cmd.finish) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
      end else if (v2_ff) begin
         bad_ff <= bad_in;
         if (v3_keep_ff) acc_ff <= acc_ff + (EW+2)'(sq_ff);
      end
   end
   assign bad_in = bad_ff || !v3_mask_ff;

   // candidate latched at window close
   logic [EW+1:0] cand_err_ff;
   logic          cand_ok_ff;
   logic [8:0]    cand_r_ff, cand_c_ff;
   logic [SW-1:0] ins_k_ff;
   logic          ins_busy_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         cand_err_ff <= acc_ff;
         cand_r_ff   <= r_ff + 9'd1;
         cand_c_ff   <= c_ff + 9'd1;
      end
   end

   // best list, one slot compared per cycle from the bottom up
   logic [EW-1:0] best_err_ff [mpssd_pkg::MAX_KEEP];
   logic [8:0]    best_r_ff   [mpssd_pkg::MAX_KEEP];
   logic [8:0]    best_c_ff   [mpssd_pkg::MAX_KEEP];

   logic [SW-1:0] top_slot;
   assign top_slot = SW'(keep_count - 4'd1);

   logic cand_better;
   assign cand_better = cand_ok_ff && (cand_err_ff < (EW+2)'(best_err_ff[ins_k_ff]));

   logic above_ok;   // candidate not below slot k-1
   assign above_ok = (ins_k_ff == '0) ||
                     !(cand_err_ff < (EW+2)'(best_err_ff[ins_k_ff - SW'(1)]));

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_busy_ff <= 1'b0;
         cand_ok_ff  <= 1'b0;
         ins_k_ff    <= '0;
      end else if (cmd.finish) begin
         cand_ok_ff  <= !bad_ff;
         ins_k_ff    <= top_slot;
         ins_busy_ff <= 1'b1;
      end else if (cmd.insert && ins_busy_ff) begin
         if (!cand_better || above_ok) ins_busy_ff <= 1'b0;
         else ins_k_ff <= ins_k_ff - SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < mpssd_pkg::MAX_KEEP; k++) begin
         if (cmd.clear) begin
            best_err_ff[k] <= mpssd_pkg::ERR_SENTINEL;
            best_r_ff[k]   <= '0;
            best_c_ff[k]   <= '0;
         end
      end
      if (cmd.insert && ins_busy_ff && cand_better) begin
         if (ins_k_ff != top_slot) begin
            best_err_ff[ins_k_ff + SW'(1)] <= best_err_ff[ins_k_ff];
            best_r_ff[ins_k_ff + SW'(1)]   <= best_r_ff[ins_k_ff];
            best_c_ff[ins_k_ff + SW'(1)]   <= best_c_ff[ins_k_ff];
         end
         if (above_ok) begin
            best_err_ff[ins_k_ff] <= cand_err_ff[EW-1:0];
            best_r_ff[ins_k_ff]   <= cand_r_ff;
            best_c_ff[ins_k_ff]   <= cand_c_ff;
         end
      end
   end

   // emit
   logic [KW-1:0] emit_k_ff;

   logic out_valid_ff;
   mpssd_pkg::rsp_type out_ff;
   logic [SW-1:0] ek;
   logic          used;
   assign ek   = emit_k_ff[SW-1:0];
   assign used = best_err_ff[ek] != mpssd_pkg::ERR_SENTINEL;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         emit_k_ff <= '0;
      end else if (cmd.emit_load) begin
         emit_k_ff <= emit_k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_ff.rank      <= 3'(emit_k_ff);
         out_ff.row_first <= used ? best_r_ff[ek] : 9'd0;
         out_ff.row_final <= used ? best_r_ff[ek] + 9'(patch_rows) - 9'd1 : 9'd0;
         out_ff.col_first <= used ? best_c_ff[ek] : 9'd0;
         out_ff.col_final <= used ? best_c_ff[ek] + 9'(patch_cols) - 9'd1 : 9'd0;
         out_ff.error_sum <= best_err_ff[ek];
         out_ff.last      <= (emit_k_ff + KW'(1) == KW'(keep_count));
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   assign sts.no_window  = (patch_rows > 5'(image_rows) && image_rows < 9'd32) ||
                           (9'(patch_rows) > image_rows) || (9'(patch_cols) > image_cols);
   assign sts.win_issued = cmd.step && last_pr && last_pc;
   assign sts.pipe_empty = !v1_ff && !v2_ff;
   assign sts.walk_done  = wdone_ff;
   assign sts.ins_done   = !ins_busy_ff || !cand_better || above_ok;
   assign sts.emit_done  = (emit_k_ff + KW'(1) == KW'(keep_count));
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.pipe_empty)
      else $error("window closed with reads in flight");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> sts.out_free)
      else $error("output register overwritten");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");

endmodule

// ===== test/masked_patch_ssd_k_best_search_unit_test.sv =====
// ----------------------------------------------------------------------------
// masked_patch_ssd_k_best_search_unit_test
// Loads image and patch stores, runs window searches under several register
// settings and checks every ranked candidate against an in-bench predictor.
// ----------------------------------------------------------------------------
module masked_patch_ssd_k_best_search_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mpssd_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mpssd_pkg::rsp_type rsp_item;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   masked_patch_ssd_k_best_search_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mpssd_pkg::req_type req_queue[$];
   mpssd_pkg::rsp_type ranked_windows[$];
   int send_idle = 30, recv_stall = 79;
   int hold_left = 0;
   logic hold_kick = 1'b0;
   int cycles = 0;
   bit failed = 0;

   // predictor state
   int img_rows = 256, img_cols = 256, pat_rows = 9, pat_cols = 9, keep = 3;
   logic [24:0] image_px[65536];
   logic [24:0] patch_px[256];

   function automatic int clamp_to(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int sq(logic [7:0] a, logic [7:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   function automatic void search_and_rank();
      int errs[mpssd_pkg::MAX_KEEP];
      int rows[mpssd_pkg::MAX_KEEP];
      int cols[mpssd_pkg::MAX_KEEP];
      int e;
      bit ok;
      logic [24:0] px, pp;
      mpssd_pkg::rsp_type r;
      for (int k = 0; k < mpssd_pkg::MAX_KEEP; k++) begin
         errs[k] = 1000000000;
         rows[k] = 0;
         cols[k] = 0;
      end
      if (pat_rows <= img_rows && pat_cols <= img_cols) begin
         for (int c = 0; c + pat_cols <= img_cols; c++) begin
            for (int w = 0; w + pat_rows <= img_rows; w++) begin
               e = 0;
               ok = 1;
               for (int pc = 0; pc < pat_cols && ok; pc++) begin
                  for (int pr = 0; pr < pat_rows && ok; pr++) begin
                     px = image_px[(w + pr) + img_rows * (c + pc)];
                     pp = patch_px[(pr + pat_rows * pc) % 256];
                     if (!px[24]) ok = 0;
                     else if (!pp[24])
                        e += sq(px[7:0], pp[7:0]) + sq(px[15:8], pp[15:8])
                           + sq(px[23:16], pp[23:16]);
                  end
               end
               if (ok) begin
                  for (int k = 0; k < keep; k++) begin
                     if (e < errs[k]) begin
                        for (int s = keep - 1; s > k; s--) begin
                           errs[s] = errs[s-1];
                           rows[s] = rows[s-1];
                           cols[s] = cols[s-1];
                        end
                        errs[k] = e;
                        rows[k] = w + 1;
                        cols[k] = c + 1;
                        break;
                     end
                  end
               end
            end
         end
      end
      for (int k = 0; k < keep; k++) begin
         r.rank = 3'(k);
         if (errs[k] != 1000000000) begin
            r.row_first = 9'(rows[k]);
            r.row_final = 9'(rows[k] + pat_rows - 1);
            r.col_first = 9'(cols[k]);
            r.col_final = 9'(cols[k] + pat_cols - 1);
         end else begin
            r.row_first = '0;
            r.row_final = '0;
            r.col_first = '0;
            r.col_final = '0;
         end
         r.error_sum = mpssd_pkg::ERR_W'(errs[k]);
         r.last = (k + 1 == keep);
         ranked_windows.push_back(r);
      end
   endfunction

   function automatic void apply_item(mpssd_pkg::req_type it);
      logic [24:0] p;
      p = {it.mask_bit, it.chan_c, it.chan_b, it.chan_a};
      case (it.mode)
         mpssd_pkg::MODE_IMAGE: if (int'(it.pixel_index) < img_rows * img_cols)
            image_px[it.pixel_index] = p;
         mpssd_pkg::MODE_PATCH: if (int'(it.pixel_index) < pat_rows * pat_cols)
            patch_px[it.pixel_index[7:0]] = p;
         mpssd_pkg::MODE_START: search_and_rank();
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_item <= req_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_kick) hold_left <= 400;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
   end

   // monitor
   always @(posedge clock) begin
      mpssd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) apply_item(req_item);
         if (rsp_valid && rsp_ready) begin
            if (ranked_windows.size() == 0) begin
               $display("%0t unexpected item: %p", $time, rsp_item);
               failed = 1;
            end else begin
               want = ranked_windows.pop_front();
               if (rsp_item.rank !== want.rank || rsp_item.row_first !== want.row_first
                   || rsp_item.row_final !== want.row_final
                   || rsp_item.col_first !== want.col_first
                   || rsp_item.col_final !== want.col_final
                   || rsp_item.error_sum !== want.error_sum || rsp_item.last !== want.last)
               begin
                  $display("%0t expected %p actual %p", $time, want, rsp_item);
                  failed = 1;
               end
            end
         end
      end
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("masked_patch_ssd_k_best_search_unit: mismatch");
         $finish;
      end
   end

   function automatic mpssd_pkg::req_type mk(logic [1:0] m, int idx, logic [7:0] a,
                                             logic [7:0] b, logic [7:0] c, logic mb);
      mpssd_pkg::req_type it;
      it.mode = m;
      it.pixel_index = 16'(idx);
      it.chan_a = a;
      it.chan_b = b;
      it.chan_c = c;
      it.mask_bit = mb;
      return it;
   endfunction

   function automatic mpssd_pkg::req_type rand_pixel(logic [1:0] m, int idx);
      return mk(m, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                (m == mpssd_pkg::MODE_IMAGE) ? ($urandom_range(9) != 0) : 1'($urandom));
   endfunction

   task automatic reg_write(logic [2:0] idx, int val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (req_queue.size() != 0 || req_valid || ranked_windows.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic configure(int ir, int ic, int pr, int pc, int kc);
      reg_write(mpssd_pkg::REG_IMAGE_ROWS, ir);
      reg_write(mpssd_pkg::REG_IMAGE_COLS, ic);
      reg_write(mpssd_pkg::REG_PATCH_ROWS, pr);
      reg_write(mpssd_pkg::REG_PATCH_COLS, pc);
      reg_write(mpssd_pkg::REG_KEEP_COUNT, kc);
      img_rows = clamp_to(ir & 'h1ff, mpssd_pkg::MAX_IMAGE_SIDE);
      img_cols = clamp_to(ic & 'h1ff, mpssd_pkg::MAX_IMAGE_SIDE);
      pat_rows = clamp_to(pr & 'h1f, mpssd_pkg::MAX_PATCH_SIDE);
      pat_cols = clamp_to(pc & 'h1f, mpssd_pkg::MAX_PATCH_SIDE);
      keep = clamp_to(kc & 'hf, mpssd_pkg::MAX_KEEP);
   endtask

   task automatic fill_stores();
      for (int i = 0; i < img_rows * img_cols; i++)
         req_queue.push_back(rand_pixel(mpssd_pkg::MODE_IMAGE, i));
      for (int i = 0; i < pat_rows * pat_cols; i++)
         req_queue.push_back(rand_pixel(mpssd_pkg::MODE_PATCH, i));
   endtask

   task automatic random_mix(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 60)
            req_queue.push_back(rand_pixel(mpssd_pkg::MODE_IMAGE,
                                           $urandom_range(img_rows*img_cols-1)));
         else if (sel < 72)
            req_queue.push_back(rand_pixel(mpssd_pkg::MODE_PATCH,
                                           $urandom_range(pat_rows*pat_cols-1)));
         else if (sel < 84)
            req_queue.push_back(mk(mpssd_pkg::MODE_START, $urandom, 8'($urandom),
                                   8'($urandom), 8'($urandom), 1'($urandom)));
         else if (sel < 90)
            req_queue.push_back(mk(MODE_NONE, $urandom, 8'($urandom), 8'($urandom),
                                   8'($urandom), 1'($urandom)));
         else
            req_queue.push_back(rand_pixel(2'($urandom_range(1)), 'hffff - $urandom_range(4000)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // uniform image, fully masked patch: every window ties at zero
      configure(4, 5, 2, 2, 3);
      for (int i = 0; i < 20; i++)
         req_queue.push_back(mk(mpssd_pkg::MODE_IMAGE, i, 7, 7, 7, 1));
      for (int i = 0; i < 4; i++)
         req_queue.push_back(mk(mpssd_pkg::MODE_PATCH, i, 0, 0, 0, 1));
      req_queue.push_back(mk(mpssd_pkg::MODE_START, 0, 0, 0, 0, 0));
      req_queue.push_back(mk(mpssd_pkg::MODE_PATCH, 0, 255, 0, 255, 0));
      req_queue.push_back(mk(mpssd_pkg::MODE_IMAGE, 6, 0, 255, 0, 1));
      req_queue.push_back(mk(mpssd_pkg::MODE_IMAGE, 13, 255, 255, 255, 0));
      req_queue.push_back(mk(mpssd_pkg::MODE_IMAGE, 65535, 0, 0, 0, 0));
      req_queue.push_back(mk(mpssd_pkg::MODE_PATCH, 4, 255, 255, 255, 1));
      req_queue.push_back(mk(MODE_NONE, 65535, 255, 255, 255, 1));
      req_queue.push_back(mk(mpssd_pkg::MODE_START, 65535, 255, 255, 255, 1));
      wait_idle();

      // zero register values, 1x1 patch, single slot
      send_idle = 79;
      recv_stall = 30;
      configure(0, 6, 1, 1, 0);
      fill_stores();
      random_mix(10);
      wait_idle();

      // patch larger than the image: all slots unused
      send_idle = 0;
      recv_stall = 0;
      configure(3, 3, 5, 2, 8);
      req_queue.push_back(mk(mpssd_pkg::MODE_START, 0, 0, 0, 0, 0));
      wait_idle();

      // tall single-column image with the tallest patch and all slots
      send_idle = 30;
      recv_stall = 79;
      configure(20, 1, 31, 1, 15);
      fill_stores();
      req_queue.push_back(mk(mpssd_pkg::MODE_START, 0, 0, 0, 0, 0));
      wait_idle();

      // bulk random with a long output hold-off
      send_idle = 0;
      recv_stall = 0;
      configure(6, 7, 3, 2, 5);
      fill_stores();
      for (int i = 0; i < 6; i++)
         req_queue.push_back(mk(mpssd_pkg::MODE_START, 0, 0, 0, 0, 0));
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      random_mix(20);
      send_idle = 79;
      recv_stall = 30;
      random_mix(20);
      wait_idle();

      if (!failed)
         $display("masked_patch_ssd_k_best_search_unit: match");
      else
         $display("masked_patch_ssd_k_best_search_unit: mismatch");
      $finish;
   end

endmodule
